### sv/wwmv_pkg.sv
package wwmv_pkg;

    // window reach; the tap walk and weight table are sized for one voxel each side
    localparam int MAX_RADIUS = 1;

    // payload widths
    localparam int VOX_W    = 16;
    localparam int WGT_W    = 16;
    localparam int TAPS     = 27;
    localparam int TAP_W    = 5;
    localparam int P_W      = 32;
    localparam int PP_W     = 64;
    localparam int S1_W     = 37;
    localparam int S2_W     = 69;
    localparam int WSUM_W   = 21;
    localparam int MUL_W    = 23;
    localparam int PROD_W   = 46;
    localparam int A_W      = 90;
    localparam int B_W      = 82;
    localparam int DEN_W    = 42;
    localparam int MNUM_W   = 45;
    localparam int MEAN_W   = 24;
    localparam int VAR_W    = 48;
    localparam int CX_W     = 8;
    localparam int CY_W     = 8;
    localparam int CZ_W     = 12;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Z = 3'd5;

    // item kinds
    localparam logic FUNC_WEIGHT = 1'b0;
    localparam logic FUNC_VOXEL  = 1'b1;

    // product sequence steps
    localparam logic [3:0] MSTEP_A0   = 4'd0;
    localparam logic [3:0] MSTEP_A1   = 4'd1;
    localparam logic [3:0] MSTEP_A2   = 4'd2;
    localparam logic [3:0] MSTEP_BLL  = 4'd3;
    localparam logic [3:0] MSTEP_BLH  = 4'd4;
    localparam logic [3:0] MSTEP_BHH  = 4'd5;
    localparam logic [3:0] MSTEP_DWW  = 4'd6;
    localparam logic [3:0] MSTEP_LAST = 4'd7;
    localparam logic [3:0] MSTEP_END  = 4'd8;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_ACC,
        ENG_DRAIN,
        ENG_MUL,
        ENG_DIV,
        ENG_DONE
    } eng_state_t;

    typedef struct packed {
        logic [CZ_W-1:0]   cz;
        logic [CY_W-1:0]   cy;
        logic [CX_W-1:0]   cx;
        logic [VAR_W-1:0]  variance;
        logic [MEAN_W-1:0] mean;
        logic              zero_sum;
    } result_t;

endpackage

### sv/weighted_window_mean_variance_3d_core.sv
// weighted 3d window mean and variance
// input stream: one beat is either a weight load (tuser low) or a voxel
// (tuser high). voxels arrive in z, y, x raster order. each voxel is stored
// in a ring of recent planes held in a single-port-read synchronous ram
// output stream: one beat per voxel that completes an interior window,
// carrying mean, variance and the window centre; tuser flags a zero weight sum
// configuration: plain write port; the user must write it only while the block is idle, the block
// itself does not enforce this; every write to a defined register restarts the volume at position zero
// flow: a weight load, a border voxel or a voxel whose window has no
// result does not start the engine. a voxel that completes a window goes
// through one ram read per tap, a shared 23x23 product unit for seven
// partial products, then a one-bit-a-cycle divider over the 90-bit
// variance numerator. the next item is taken once the result has moved
// into the output register
// reset: weights clear to zero, sizes 256, radii 1, position zero; the
// voxel ram is not cleared, since every window read lands on voxels of the
// current volume
// output stall: a finished result waits in the output register while the
// next item is already at work; the engine holds its own result only if the
// output register is still full and not being read when it finishes
module weighted_window_mean_variance_3d_core #(
    parameter int MAX_ROW         = 256,
    parameter int MAX_COLUMN_ROWS = 256,
    parameter int MAX_PLANES      = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [39:0]                         s_axis_tdata,  // weight_index, weight_value, voxel_value
    input  logic                                s_axis_tuser,  // func
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [103:0]                        m_axis_tdata,  // mean_value, variance_value, centre_x, centre_y, centre_z
    output logic                                m_axis_tuser,  // zero_weight_sum
    input  logic                                cfg_we,
    input  logic [wwmv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wwmv_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import wwmv_pkg::*;

    // ring depth covers two planes, two rows and three voxels at the largest radius
    localparam int HIST_DEPTH = 2 * MAX_RADIUS * MAX_ROW * MAX_COLUMN_ROWS
                              + 2 * MAX_RADIUS * MAX_ROW + 2 * MAX_RADIUS + 1;
    localparam int AW  = $clog2(HIST_DEPTH);
    localparam int XW  = $clog2(MAX_ROW + 1);
    localparam int YW  = $clog2(MAX_COLUMN_ROWS + 1);
    localparam int ZW  = $clog2(MAX_PLANES + 1);
    localparam int XPW = $clog2(MAX_ROW);
    localparam int YPW = $clog2(MAX_COLUMN_ROWS);
    localparam int ZPW = $clog2(MAX_PLANES);
    localparam int PW  = $clog2(MAX_ROW * MAX_COLUMN_ROWS + 1);

    // configuration registers
    logic [8:0]     size_x_reg, size_y_reg;
    logic [12:0]    size_z_reg;
    logic           rx_reg, ry_reg, rz_reg;

    // volume position and ring write pointer
    logic [XPW-1:0] pos_x_reg;
    logic [YPW-1:0] pos_y_reg;
    logic [ZPW-1:0] pos_z_reg;
    logic [AW-1:0]  ring_ptr_reg;

    // output register
    logic           out_valid_reg;
    result_t        out_res_reg;

    logic [XW-1:0]  eff_x;
    logic [YW-1:0]  eff_y;
    logic [ZW-1:0]  eff_z;
    logic [PW-1:0]  plane;
    logic           in_fire, voxel_fire, weight_fire, interior, eng_start;
    logic           end_x, end_y, end_z;
    logic           cfg_hit;
    logic [TAP_W-1:0] in_wt_idx;
    logic [WGT_W-1:0] in_wt_val;
    logic [VOX_W-1:0] in_voxel;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    logic [VOX_W-1:0] ram_rdata;
    logic           eng_idle, eng_res_valid, res_take;
    result_t        eng_res;

    // sizes of zero act as one, oversize acts as the maximum
    always_comb
    begin
        if (size_x_reg == '0)
            eff_x = XW'(1);
        else if (32'(size_x_reg) > MAX_ROW)
            eff_x = XW'(MAX_ROW);
        else
            eff_x = XW'(size_x_reg);
        if (size_y_reg == '0)
            eff_y = YW'(1);
        else if (32'(size_y_reg) > MAX_COLUMN_ROWS)
            eff_y = YW'(MAX_COLUMN_ROWS);
        else
            eff_y = YW'(size_y_reg);
        if (size_z_reg == '0)
            eff_z = ZW'(1);
        else if (32'(size_z_reg) > MAX_PLANES)
            eff_z = ZW'(MAX_PLANES);
        else
            eff_z = ZW'(size_z_reg);
        plane = PW'(eff_x) * PW'(eff_y);
    end

    assign in_wt_idx   = s_axis_tdata[4:0];
    assign in_wt_val   = s_axis_tdata[20:5];
    assign in_voxel    = s_axis_tdata[36:21];

    assign s_axis_tready = eng_idle;
    assign in_fire     = s_axis_tvalid && s_axis_tready;
    assign voxel_fire  = in_fire && (s_axis_tuser == FUNC_VOXEL);
    assign weight_fire = in_fire && (s_axis_tuser == FUNC_WEIGHT);

    // window complete once the newest voxel sits 2r past the start on each axis
    assign interior  = (pos_x_reg >= XPW'({rx_reg, 1'b0}))
                    && (pos_y_reg >= YPW'({ry_reg, 1'b0}))
                    && (pos_z_reg >= ZPW'({rz_reg, 1'b0}));
    assign eng_start = voxel_fire && interior;

    assign end_x = 32'(pos_x_reg) + 32'd1 >= 32'(eff_x);
    assign end_y = 32'(pos_y_reg) + 32'd1 >= 32'(eff_y);
    assign end_z = 32'(pos_z_reg) + 32'd1 >= 32'(eff_z);

    assign cfg_hit = cfg_we && (cfg_index <= CFG_RADIUS_Z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= 9'd256;
            size_y_reg <= 9'd256;
            size_z_reg <= 13'd256;
            rx_reg     <= 1'b1;
            ry_reg     <= 1'b1;
            rz_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SIZE_X:   size_x_reg <= cfg_data[8:0];
                CFG_SIZE_Y:   size_y_reg <= cfg_data[8:0];
                CFG_SIZE_Z:   size_z_reg <= cfg_data;
                CFG_RADIUS_X: rx_reg     <= cfg_data[0];
                CFG_RADIUS_Y: ry_reg     <= cfg_data[0];
                CFG_RADIUS_Z: rz_reg     <= cfg_data[0];
                default:      rx_reg     <= rx_reg;
            endcase
        end
    end

    // raster position; any write to a defined register restarts the volume
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            pos_z_reg    <= '0;
            ring_ptr_reg <= '0;
        end
        else
        begin
            if (voxel_fire)
            begin
                ring_ptr_reg <= (ring_ptr_reg == AW'(HIST_DEPTH - 1)) ? '0
                                                                      : ring_ptr_reg + 1'b1;
            end
            if (cfg_hit)
            begin
                pos_x_reg <= '0;
                pos_y_reg <= '0;
                pos_z_reg <= '0;
            end
            else if (voxel_fire)
            begin
                if (!end_x)
                begin
                    pos_x_reg <= pos_x_reg + 1'b1;
                end
                else
                begin
                    pos_x_reg <= '0;
                    if (!end_y)
                    begin
                        pos_y_reg <= pos_y_reg + 1'b1;
                    end
                    else
                    begin
                        pos_y_reg <= '0;
                        pos_z_reg <= end_z ? '0 : pos_z_reg + 1'b1;
                    end
                end
            end
        end
    end

    // output register parts the engine from the receiver
    assign res_take = eng_res_valid && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_res_reg <= eng_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'h0, out_res_reg.cz, out_res_reg.cy, out_res_reg.cx,
                            out_res_reg.variance, out_res_reg.mean};
    assign m_axis_tuser  = out_res_reg.zero_sum;

    // voxel ring
    wwmv_ram #(
        .WIDTH (VOX_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (voxel_fire),
        .waddr (ring_ptr_reg),
        .wdata (in_voxel),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // tap accumulation, products and division
    wwmv_engine #(
        .HIST_DEPTH      (HIST_DEPTH),
        .MAX_ROW         (MAX_ROW),
        .MAX_COLUMN_ROWS (MAX_COLUMN_ROWS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .wt_we     (weight_fire),
        .wt_idx    (in_wt_idx),
        .wt_val    (in_wt_val),
        .start     (eng_start),
        .newest    (ring_ptr_reg),
        .rx        (rx_reg),
        .ry        (ry_reg),
        .rz        (rz_reg),
        .eff_x     (eff_x),
        .plane     (plane),
        .cx        (CX_W'(32'(pos_x_reg) - 32'(rx_reg))),
        .cy        (CY_W'(32'(pos_y_reg) - 32'(ry_reg))),
        .cz        (CZ_W'(32'(pos_z_reg) - 32'(rz_reg))),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .idle      (eng_idle),
        .res_valid (eng_res_valid),
        .res_take  (res_take),
        .res       (eng_res)
    );

    // a finished result lands in a free output register on the next edge
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        eng_res_valid && !m_axis_tvalid |=> m_axis_tvalid)
        else $error("finished result not moved to output register");

    // a voxel completing a window occupies the engine
    a_window_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (s_axis_tuser == FUNC_VOXEL) && interior |=> !s_axis_tready)
        else $error("engine ready right after window start");

    // input is only taken when no result is pending in the engine
    a_ready_clean: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !eng_res_valid)
        else $error("input ready with engine result pending");

endmodule

### sv/wwmv_ram.sv
module wwmv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/wwmv_div.sv
module wwmv_div #(
    parameter int NW = 45,
    parameter int DW = 21
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] nq_reg;
    logic [DW-1:0] r_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          ge;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        shifted = {r_reg, nq_reg[NW-1]};
        diff    = shifted - {1'b0, den_reg};
        ge      = shifted >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg  <= num;
            r_reg   <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            nq_reg <= {nq_reg[NW-2:0], ge};
            r_reg  <= ge ? diff[DW-1:0] : shifted[DW-1:0];
        end
    end

    assign busy = busy_reg;
    assign quo  = nq_reg;
    assign rem  = r_reg;

endmodule

### sv/wwmv_engine.sv
module wwmv_engine #(
    parameter int HIST_DEPTH      = 131587,
    parameter int MAX_ROW         = 256,
    parameter int MAX_COLUMN_ROWS = 256
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                wt_we,
    input  logic [wwmv_pkg::TAP_W-1:0]                          wt_idx,
    input  logic [wwmv_pkg::WGT_W-1:0]                          wt_val,
    input  logic                                                start,
    input  logic [$clog2(HIST_DEPTH)-1:0]                       newest,
    input  logic                                                rx,
    input  logic                                                ry,
    input  logic                                                rz,
    input  logic [$clog2(MAX_ROW+1)-1:0]                        eff_x,
    input  logic [$clog2(MAX_ROW*MAX_COLUMN_ROWS+1)-1:0]        plane,
    input  logic [wwmv_pkg::CX_W-1:0]                           cx,
    input  logic [wwmv_pkg::CY_W-1:0]                           cy,
    input  logic [wwmv_pkg::CZ_W-1:0]                           cz,
    output logic                                                ram_re,
    output logic [$clog2(HIST_DEPTH)-1:0]                       ram_raddr,
    input  logic [wwmv_pkg::VOX_W-1:0]                          ram_rdata,
    output logic                                                idle,
    output logic                                                res_valid,
    input  logic                                                res_take,
    output wwmv_pkg::result_t                                   res
);

    import wwmv_pkg::*;

    localparam int AW = $clog2(HIST_DEPTH);

    eng_state_t state_reg, state_next;

    logic [WGT_W-1:0] wtab_reg [TAPS];

    logic [AW-1:0]     newest_reg;
    logic [CX_W-1:0]   cx_reg;
    logic [CY_W-1:0]   cy_reg;
    logic [CZ_W-1:0]   cz_reg;
    logic [1:0]        i_reg, j_reg, k_reg;
    logic [TAP_W-1:0]  t_reg;
    logic [AW-1:0]     di_reg, dj_reg, dk_reg;
    logic              v1_reg, v2_reg, v3_reg;
    logic [WGT_W-1:0]  w1_reg;
    logic [P_W-1:0]    p_reg;
    logic [PP_W-1:0]   pp_reg;
    logic [S1_W-1:0]   s1_reg;
    logic [S2_W-1:0]   s2_reg;
    logic [WSUM_W-1:0] wt_reg;
    logic [3:0]        m_reg;
    logic              mv_reg;
    logic [3:0]        pstep_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [A_W-1:0]    a_reg;
    logic [B_W-1:0]    b_reg;
    logic [DEN_W-1:0]  d_reg;
    logic              neg_reg;
    result_t           res_reg;

    logic              last_i, last_j, last_k, last_tap;
    logic [AW:0]       dsum;
    logic [AW:0]       addr_w;
    logic              acc_issue, mean_start, var_start, fin, fin_zero;
    logic [MUL_W-1:0]  opa, opb;
    logic [A_W-1:0]    var_num;
    logic              mean_busy, var_busy;
    logic [MNUM_W-1:0] mean_quo;
    logic [WSUM_W-1:0] mean_rem;
    logic [A_W-1:0]    var_quo;
    logic [DEN_W-1:0]  var_rem;
    logic [A_W:0]      var_inc;
    logic [VAR_W-1:0]  neg_mag;
    result_t           fin_res;

    // tap walk and ring address
    always_comb
    begin
        last_i   = i_reg == {rx, 1'b0};
        last_j   = j_reg == {ry, 1'b0};
        last_k   = k_reg == {rz, 1'b0};
        last_tap = last_i && last_j && last_k;
        dsum     = {1'b0, dk_reg} + {1'b0, dj_reg} + {1'b0, di_reg};
        if ({1'b0, newest_reg} >= dsum)
        begin
            addr_w = {1'b0, newest_reg} - dsum;
        end
        else
        begin
            addr_w = {1'b0, newest_reg} + (AW+1)'(HIST_DEPTH) - dsum;
        end
        ram_raddr = addr_w[AW-1:0];
    end

    // operands of the shared product unit
    always_comb
    begin
        unique case (m_reg)
            MSTEP_A0:
            begin
                opa = s2_reg[22:0];
                opb = MUL_W'(wt_reg);
            end
            MSTEP_A1:
            begin
                opa = s2_reg[45:23];
                opb = MUL_W'(wt_reg);
            end
            MSTEP_A2:
            begin
                opa = s2_reg[68:46];
                opb = MUL_W'(wt_reg);
            end
            MSTEP_BLL:
            begin
                opa = MUL_W'(s1_reg[18:0]);
                opb = MUL_W'(s1_reg[18:0]);
            end
            MSTEP_BLH:
            begin
                opa = MUL_W'(s1_reg[18:0]);
                opb = MUL_W'(s1_reg[36:19]);
            end
            MSTEP_BHH:
            begin
                opa = MUL_W'(s1_reg[36:19]);
                opb = MUL_W'(s1_reg[36:19]);
            end
            MSTEP_DWW:
            begin
                opa = MUL_W'(wt_reg);
                opb = MUL_W'(wt_reg);
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
        var_num = (a_reg >= A_W'(b_reg)) ? a_reg - A_W'(b_reg) : A_W'(b_reg) - a_reg;
    end

    // final saturation and sign
    always_comb
    begin
        var_inc = {1'b0, var_quo} + (A_W+1)'(var_rem != '0);
        if ((|var_inc[A_W:VAR_W]) || (var_inc[VAR_W-1] && (|var_inc[VAR_W-2:0])))
        begin
            neg_mag = {1'b1, {(VAR_W-1){1'b0}}};
        end
        else
        begin
            neg_mag = var_inc[VAR_W-1:0];
        end
        fin_res.cx       = cx_reg;
        fin_res.cy       = cy_reg;
        fin_res.cz       = cz_reg;
        fin_res.zero_sum = 1'b0;
        fin_res.mean     = (|mean_quo[MNUM_W-1:MEAN_W]) ? '1 : mean_quo[MEAN_W-1:0];
        if (neg_reg)
        begin
            fin_res.variance = VAR_W'(0) - neg_mag;
        end
        else if (|var_quo[A_W-1:VAR_W-1])
        begin
            fin_res.variance = {1'b0, {(VAR_W-1){1'b1}}};
        end
        else
        begin
            fin_res.variance = var_quo[VAR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ENG_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        acc_issue  = 1'b0;
        mean_start = 1'b0;
        var_start  = 1'b0;
        fin        = 1'b0;
        fin_zero   = 1'b0;
        idle       = 1'b0;
        res_valid  = 1'b0;
        unique case (state_reg)
            ENG_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    state_next = ENG_ACC;
                end
            end
            ENG_ACC:
            begin
                acc_issue = 1'b1;
                if (last_tap)
                begin
                    state_next = ENG_DRAIN;
                end
            end
            ENG_DRAIN:
            begin
                if (!v1_reg && !v2_reg && !v3_reg)
                begin
                    mean_start = wt_reg != '0;
                    state_next = ENG_MUL;
                end
            end
            ENG_MUL:
            begin
                if (m_reg == MSTEP_END)
                begin
                    if (wt_reg == '0)
                    begin
                        fin_zero   = 1'b1;
                        state_next = ENG_DONE;
                    end
                    else
                    begin
                        var_start  = 1'b1;
                        state_next = ENG_DIV;
                    end
                end
            end
            ENG_DIV:
            begin
                if (!mean_busy && !var_busy)
                begin
                    fin        = 1'b1;
                    state_next = ENG_DONE;
                end
            end
            ENG_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = ENG_IDLE;
                end
            end
            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    assign ram_re = acc_issue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < TAPS; n++)
            begin
                wtab_reg[n] <= '0;
            end
        end
        else if (wt_we && (wt_idx < TAP_W'(TAPS)))
        begin
            wtab_reg[wt_idx] <= wt_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            mv_reg <= 1'b0;
            m_reg  <= '0;
        end
        else
        begin
            v1_reg <= acc_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            mv_reg <= (state_reg == ENG_MUL) && (m_reg < MSTEP_LAST);
            if (state_reg == ENG_MUL)
            begin
                m_reg <= m_reg + 1'b1;
            end
            else
            begin
                m_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ENG_IDLE && start)
        begin
            newest_reg <= newest;
            cx_reg     <= cx;
            cy_reg     <= cy;
            cz_reg     <= cz;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            t_reg      <= '0;
            di_reg     <= AW'({rx, 1'b0});
            dj_reg     <= ry ? AW'(eff_x) << 1 : '0;
            dk_reg     <= rz ? AW'(plane) << 1 : '0;
            s1_reg     <= '0;
            s2_reg     <= '0;
            wt_reg     <= '0;
        end
        else
        begin
            if (acc_issue)
            begin
                w1_reg <= wtab_reg[t_reg];
                wt_reg <= wt_reg + WSUM_W'(wtab_reg[t_reg]);
                t_reg  <= t_reg + 1'b1;
                if (!last_i)
                begin
                    i_reg  <= i_reg + 1'b1;
                    di_reg <= di_reg - 1'b1;
                end
                else
                begin
                    i_reg  <= '0;
                    di_reg <= AW'({rx, 1'b0});
                    if (!last_j)
                    begin
                        j_reg  <= j_reg + 1'b1;
                        dj_reg <= dj_reg - AW'(eff_x);
                    end
                    else
                    begin
                        j_reg  <= '0;
                        dj_reg <= ry ? AW'(eff_x) << 1 : '0;
                        k_reg  <= k_reg + 1'b1;
                        dk_reg <= dk_reg - AW'(plane);
                    end
                end
            end
            if (v2_reg)
            begin
                s1_reg <= s1_reg + S1_W'(p_reg);
            end
            if (v3_reg)
            begin
                s2_reg <= s2_reg + S2_W'(pp_reg);
            end
        end
        p_reg  <= w1_reg * ram_rdata;
        pp_reg <= PP_W'(p_reg) * PP_W'(p_reg);

        prod_reg  <= PROD_W'(opa) * PROD_W'(opb);
        pstep_reg <= m_reg;
        if (mv_reg)
        begin
            unique case (pstep_reg)
                MSTEP_A0:  a_reg <= A_W'(prod_reg);
                MSTEP_A1:  a_reg <= a_reg + (A_W'(prod_reg) << 23);
                MSTEP_A2:  a_reg <= a_reg + (A_W'(prod_reg) << 46);
                MSTEP_BLL: b_reg <= B_W'(prod_reg) << 8;
                MSTEP_BLH: b_reg <= b_reg + (B_W'(prod_reg) << 28);
                MSTEP_BHH: b_reg <= b_reg + (B_W'(prod_reg) << 46);
                MSTEP_DWW: d_reg <= prod_reg[DEN_W-1:0];
                default:   d_reg <= d_reg;
            endcase
        end
        if (var_start)
        begin
            neg_reg <= a_reg < A_W'(b_reg);
        end
        if (fin)
        begin
            res_reg <= fin_res;
        end
        else if (fin_zero)
        begin
            res_reg.cx       <= cx_reg;
            res_reg.cy       <= cy_reg;
            res_reg.cz       <= cz_reg;
            res_reg.mean     <= '0;
            res_reg.variance <= '0;
            res_reg.zero_sum <= 1'b1;
        end
    end

    wwmv_div #(
        .NW (MNUM_W),
        .DW (WSUM_W)
    ) u_mean_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mean_start),
        .num   ({s1_reg, 8'h00}),
        .den   (wt_reg),
        .busy  (mean_busy),
        .quo   (mean_quo),
        .rem   (mean_rem)
    );

    wwmv_div #(
        .NW (A_W),
        .DW (DEN_W)
    ) u_var_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (var_start),
        .num   (var_num),
        .den   (d_reg),
        .busy  (var_busy),
        .quo   (var_quo),
        .rem   (var_rem)
    );

    // mean remainder only matters for flooring, which the quotient already does
    assign res = (mean_rem == mean_rem) ? res_reg : res_reg;

endmodule

### verif/testbench.sv
module testbench;
    import wwmv_pkg::*;

    // index with no register behind it: the write must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;

    localparam logic [47:0] VAR_POS_LIMIT = 48'h7FFF_FFFF_FFFF;
    localparam logic [127:0] VAR_NEG_LIMIT = 128'h8000_0000_0000;
    localparam int SETTLE_CYCLES = 200;
    localparam int BEAT_TARGET = 1550;

    typedef struct packed {
        logic [CZ_W-1:0]   cz;
        logic [CY_W-1:0]   cy;
        logic [CX_W-1:0]   cx;
        logic [VAR_W-1:0]  variance;
        logic [MEAN_W-1:0] mean;
        logic              zero_sum;
    } window_stats_t;

    // one row of the directed table: a register write or a stream beat
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        int                   reg_val;
        logic                 func;
        logic [4:0]           widx;
        logic [15:0]          wval;
        logic [15:0]          vox;
        bit                   typed;
        logic [MEAN_W-1:0]    t_mean;
        logic [VAR_W-1:0]     t_var;
        logic                 t_zero;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [103:0]          m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    weighted_window_mean_variance_3d_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // weight_index, weight_value, voxel_value
        .s_axis_tuser  (s_axis_tuser),   // func
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // mean, variance, centre_x, centre_y, centre_z
        .m_axis_tuser  (m_axis_tuser),   // zero_weight_sum
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // shadow of the block state, kept by the predictor
    logic [15:0] tap_weight [TAPS];
    logic [20:0] weight_sum;
    int          cur_x, cur_y, cur_z;
    int          raw_sx, raw_sy, raw_sz;
    int          rad_x, rad_y, rad_z;
    logic [15:0] volume_voxels [int];   // keyed by raster offset in the volume

    window_stats_t pending_stats [$];
    int            mismatches;
    int            beats_sent;
    bit            quiet;               // burst phase: no gaps on either side

    function automatic int clamp_size(int raw, int maxv);
        if (raw == 0)
            return 1;
        return raw > maxv ? maxv : raw;
    endfunction

    // weight sum over the taps of the active window
    function automatic void refresh_weight_sum();
        int ntaps;
        ntaps = (2 * rad_x + 1) * (2 * rad_y + 1) * (2 * rad_z + 1);
        weight_sum = '0;
        for (int t = 0; t < ntaps; t++)
            weight_sum += tap_weight[t];
    endfunction

    function automatic void reset_shadow();
        foreach (tap_weight[t])
            tap_weight[t] = '0;
        weight_sum = '0;
        cur_x = 0; cur_y = 0; cur_z = 0;
        raw_sx = 256; raw_sy = 256; raw_sz = 256;
        rad_x = 1; rad_y = 1; rad_z = 1;
    endfunction

    function automatic void shadow_reg_write(logic [CFG_IDX_W-1:0] idx, int val);
        case (idx)
            CFG_SIZE_X:   raw_sx = val & 'h1FF;
            CFG_SIZE_Y:   raw_sy = val & 'h1FF;
            CFG_SIZE_Z:   raw_sz = val & 'h1FFF;
            CFG_RADIUS_X: rad_x = val & 1;
            CFG_RADIUS_Y: rad_y = val & 1;
            CFG_RADIUS_Z: rad_z = val & 1;
            default:      return;
        endcase
        cur_x = 0; cur_y = 0; cur_z = 0;
        refresh_weight_sum();
    endfunction

    // windowed weighted mean and variance for one beat; returns 1 with a result
    function automatic bit predict_window_stats(logic func, logic [4:0] widx,
                                                logic [15:0] wval, logic [15:0] vox,
                                                output window_stats_t res);
        int          sx, sy, sz, lin, d, tap;
        logic [127:0] s1, s2, p, wt, a, b, q, den;
        logic [127:0] mean_full;
        bit          got;
        res = '0;
        got = 0;
        if (func == FUNC_WEIGHT)
        begin
            if (widx < TAPS)
                tap_weight[widx] = wval;
            refresh_weight_sum();
            return 0;
        end
        sx = clamp_size(raw_sx, 256);
        sy = clamp_size(raw_sy, 256);
        sz = clamp_size(raw_sz, 4096);
        lin = (cur_z * sy + cur_y) * sx + cur_x;
        volume_voxels[lin] = vox;
        if (cur_x >= 2 * rad_x && cur_y >= 2 * rad_y && cur_z >= 2 * rad_z)
        begin
            s1 = '0; s2 = '0; tap = 0;
            for (int k = 0; k <= 2 * rad_z; k++)
                for (int j = 0; j <= 2 * rad_y; j++)
                    for (int i = 0; i <= 2 * rad_x; i++)
                    begin
                        d = (2 * rad_z - k) * sx * sy + (2 * rad_y - j) * sx + (2 * rad_x - i);
                        p = 128'(tap_weight[tap]) * 128'(volume_voxels[lin - d]);
                        s1 += p;
                        s2 += p * p;
                        tap++;
                    end
            wt = 128'(weight_sum);
            if (wt != 0)
            begin
                mean_full = (s1 << 8) / wt;
                res.mean = mean_full > 128'hFF_FFFF ? 24'hFF_FFFF : mean_full[23:0];
                a = s2 * wt;
                b = (s1 * s1) << 8;
                den = wt * wt;
                if (a >= b)
                begin
                    q = (a - b) / den;
                    res.variance = q > 128'(VAR_POS_LIMIT) ? VAR_POS_LIMIT : q[47:0];
                end
                else
                begin
                    // floor of a negative quotient: round the magnitude up
                    q = (b - a) / den;
                    if ((b - a) % den != 0)
                        q += 1;
                    if (q > VAR_NEG_LIMIT)
                        q = VAR_NEG_LIMIT;
                    res.variance = 48'(0) - q[47:0];
                end
            end
            res.cx = 8'(cur_x - rad_x);
            res.cy = 8'(cur_y - rad_y);
            res.cz = 12'(cur_z - rad_z);
            res.zero_sum = (wt == 0);
            got = 1;
        end
        // raster advance, wrapping into a new volume
        cur_x++;
        if (cur_x >= sx)
        begin
            cur_x = 0;
            cur_y++;
            if (cur_y >= sy)
            begin
                cur_y = 0;
                cur_z++;
                if (cur_z >= sz)
                    cur_z = 0;
            end
        end
        return got;
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // hard stop
    initial
    begin
        #20_000_000;
        $display("** weighted_window_mean_variance_3d_core: FAILED **");
        $finish;
    end

    // wait until the block has drained every result and any trailing voxel
    task automatic wait_idle();
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        wait_idle();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_DATA_W'(val);
        @(negedge clk);
        cfg_we    = 1'b0;
        shadow_reg_write(idx, val);
    endtask

    // send one beat; the expectation is the predictor's unless a typed one is given
    task automatic send_beat(logic func, logic [4:0] widx, logic [15:0] wval,
                             logic [15:0] vox, bit typed, window_stats_t typed_res);
        int            gap;
        window_stats_t res;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = func;
        s_axis_tdata  = {3'b0, vox, wval, widx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (predict_window_stats(func, widx, wval, vox, res))
            pending_stats.push_back(typed ? typed_res : res);
        beats_sent++;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_random_weight();
        logic [15:0] w;
        case ($urandom_range(0, 3))
            0:       w = 16'h0000;
            1:       w = 16'h0100;
            default: w = 16'($urandom);
        endcase
        send_beat(FUNC_WEIGHT, 5'($urandom_range(0, 31)), w, 16'($urandom), 0, '0);
    endtask

    // result side: random stall per beat, then field by field check
    initial
    begin
        int            stall;
        window_stats_t got;
        window_stats_t want;
        m_axis_tready = 1'b0;
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 4);
            m_axis_tready = 1'b0;
            if (stall != 0)
                repeat (stall) @(negedge clk);
            m_axis_tready = 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && rst_n));
            got.mean     = m_axis_tdata[23:0];
            got.variance = m_axis_tdata[71:24];
            got.cx       = m_axis_tdata[79:72];
            got.cy       = m_axis_tdata[87:80];
            got.cz       = m_axis_tdata[99:88];
            got.zero_sum = m_axis_tuser;
            if (pending_stats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", got);
            end
            else
            begin
                want = pending_stats.pop_front();
                if (got.mean !== want.mean || got.variance !== want.variance
                    || got.cx !== want.cx || got.cy !== want.cy || got.cz !== want.cz
                    || got.zero_sum !== want.zero_sum)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, actual %p", want, got);
                end
            end
            @(negedge clk);
        end
    end

    // stimulus
    initial
    begin
        dir_row_t      dir_rows [$];
        window_stats_t typed_res;
        int            sizes [6];
        int            nvox;
        int            order;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_WEIGHT;
        cfg_we    = 1'b0;
        cfg_index = CFG_SIZE_X;
        cfg_data  = '0;
        mismatches = 0;
        beats_sent = 0;
        quiet = 0;
        reset_shadow();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: a 1x1x3 column with a window along z only
        dir_rows = '{
            '{1, CFG_SIZE_X,   1, 0, 0, 0, 0, 0, 0, 0, 0},
            '{1, CFG_SIZE_Y,   1, 0, 0, 0, 0, 0, 0, 0, 0},
            '{1, CFG_SIZE_Z,   3, 0, 0, 0, 0, 0, 0, 0, 0},
            '{1, CFG_RADIUS_X, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{1, CFG_RADIUS_Y, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{1, CFG_RADIUS_Z, 1, 0, 0, 0, 0, 0, 0, 0, 0},
            '{1, CFG_NONE,     0, 0, 0, 0, 0, 0, 0, 0, 0},
            // weights still zero after reset: flag set, values zero
            '{0, CFG_SIZE_X, 0, FUNC_VOXEL, 0, 0, 16'h0000, 0, 0, 0, 0},
            '{0, CFG_SIZE_X, 0, FUNC_VOXEL, 0, 0, 16'hFFFF, 0, 0, 0, 0},
            '{0, CFG_SIZE_X, 0, FUNC_VOXEL, 0, 0, 16'h1234, 1, 24'h0, 48'h0, 1'b1},
            // unit weights, full-scale voxels: mean is the voxel itself
            '{0, CFG_SIZE_X, 0, FUNC_WEIGHT, 0, 16'h0100, 0, 0, 0, 0, 0},
            '{0, CFG_SIZE_X, 0, FUNC_WEIGHT, 1, 16'h0100, 0, 0, 0, 0, 0},
            '{0, CFG_SIZE_X, 0, FUNC_WEIGHT, 2, 16'h0100, 0, 0, 0, 0, 0},
            '{0, CFG_SIZE_X, 0, FUNC_VOXEL, 0, 0, 16'hFFFF, 0, 0, 0, 0},
            '{0, CFG_SIZE_X, 0, FUNC_VOXEL, 0, 0, 16'hFFFF, 0, 0, 0, 0},
            '{0, CFG_SIZE_X, 0, FUNC_VOXEL, 0, 0, 16'hFFFF, 1, 24'hFFFF00, 48'h0, 1'b0},
            // index past the table is dropped, index past the window kept unused
            '{0, CFG_SIZE_X, 0, FUNC_WEIGHT, 31, 16'hFFFF, 0, 0, 0, 0, 0},
            '{0, CFG_SIZE_X, 0, FUNC_WEIGHT, 26, 16'hFFFF, 0, 0, 0, 0, 0},
            // largest weight on tap 0, tap 1 cleared, tap 2 keeps its unit weight
            '{0, CFG_SIZE_X, 0, FUNC_WEIGHT, 0, 16'hFFFF, 0, 0, 0, 0, 0},
            '{0, CFG_SIZE_X, 0, FUNC_WEIGHT, 1, 16'h0000, 0, 0, 0, 0, 0},
            '{0, CFG_SIZE_X, 0, FUNC_VOXEL, 0, 0, 16'hFFFF, 0, 0, 0, 0},
            '{0, CFG_SIZE_X, 0, FUNC_VOXEL, 0, 0, 16'h0001, 0, 0, 0, 0},
            '{0, CFG_SIZE_X, 0, FUNC_VOXEL, 0, 0, 16'h8000, 0, 0, 0, 0},
            '{0, CFG_SIZE_X, 0, FUNC_VOXEL, 0, 0, 16'h7FFF, 0, 0, 0, 0}
        };
        foreach (dir_rows[r])
        begin
            if (dir_rows[r].is_cfg)
                write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
            else
            begin
                typed_res = '0;
                typed_res.mean     = dir_rows[r].t_mean;
                typed_res.variance = dir_rows[r].t_var;
                typed_res.zero_sum = dir_rows[r].t_zero;
                typed_res.cz       = 12'd1;
                send_beat(dir_rows[r].func, dir_rows[r].widx, dir_rows[r].wval,
                          dir_rows[r].vox, dir_rows[r].typed, typed_res);
            end
        end

        // random phases; the first few pin the register extremes
        for (int ph = 0; beats_sent < BEAT_TARGET; ph++)
        begin
            case (ph)
                0:       sizes = '{256, 1, 1, 1, 0, 0};
                1:       sizes = '{1, 1, 8191, 0, 0, 1};
                2:       sizes = '{0, 0, 0, 0, 0, 0};
                3:       sizes = '{511, 256, 4096, 1, 1, 1};
                4:       sizes = '{1, 256, 1, 0, 1, 0};
                default: sizes = '{$urandom_range(1, 7), $urandom_range(1, 6),
                                   $urandom_range(1, 5), $urandom_range(0, 1),
                                   $urandom_range(0, 1), $urandom_range(0, 1)};
            endcase
            // each write restarts the volume, so the order does not matter
            order = $urandom_range(0, 5);
            for (int n = 0; n < 6; n++)
                write_reg(CFG_IDX_W'((order + n) % 6), sizes[(order + n) % 6]);
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_NONE, $urandom);
            quiet = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(0, 8))
                send_random_weight();
            nvox = (ph < 5) ? (ph == 0 ? 260 : 60) : $urandom_range(20, 120);
            for (int v = 0; v < nvox; v++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_random_weight();
                send_beat(FUNC_VOXEL, 5'($urandom), 16'($urandom),
                          ($urandom_range(0, 15) == 0) ? 16'hFFFF : 16'($urandom), 0, '0);
            end
        end

        quiet = 0;
        wait_idle();
        if (mismatches == 0 && pending_stats.size() == 0)
            $display("** weighted_window_mean_variance_3d_core: PASSED **");
        else
            $display("** weighted_window_mean_variance_3d_core: FAILED **");
        $finish;
    end

endmodule
